[design/ctl_pkg.sv]
package ctl_pkg;

  localparam int DefLengthBits   = 16;
  localparam int DefPositionBits = 32;

  localparam int KIND_W = 6;
  localparam int ERR_W  = 3;

  // lexer modes
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_INT     = 4'd2,
    M_FRAC    = 4'd3,
    M_SYM     = 4'd4,
    M_CHOPEN  = 4'd5,
    M_CHBODY  = 4'd6,
    M_STRING  = 4'd7,
    M_COMMENT = 4'd8
  } mode_t;

  // token kinds
  localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd1;
  localparam logic [KIND_W-1:0] K_INT    = 6'd2;
  localparam logic [KIND_W-1:0] K_FLOAT  = 6'd3;
  localparam logic [KIND_W-1:0] K_CHAR   = 6'd4;
  localparam logic [KIND_W-1:0] K_STRING = 6'd5;
  localparam logic [KIND_W-1:0] K_SYM0   = 6'd6;
  localparam logic [KIND_W-1:0] K_COMBO0 = 6'd27;
  localparam logic [KIND_W-1:0] K_KW0    = 6'd46;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] E_UNKNOWN  = 3'd1;
  localparam logic [ERR_W-1:0] E_IDENT    = 3'd2;
  localparam logic [ERR_W-1:0] E_DIGIT    = 3'd3;
  localparam logic [ERR_W-1:0] E_CHARLIT  = 3'd4;
  localparam logic [ERR_W-1:0] E_STRING   = 3'd5;

  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // one-character symbol index, 31 when none
  function automatic logic [4:0] sym_index(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd31;
    case (c)
      8'h7B: r = 5'd0;  8'h7D: r = 5'd1;  8'h28: r = 5'd2;  8'h29: r = 5'd3;
      8'h2C: r = 5'd4;  8'h3B: r = 5'd5;  8'h3A: r = 5'd6;  8'h2B: r = 5'd7;
      8'h2D: r = 5'd8;  8'h2A: r = 5'd9;  8'h2F: r = 5'd10; 8'h3C: r = 5'd11;
      8'h3E: r = 5'd12; 8'h3D: r = 5'd13; 8'h2E: r = 5'd14; 8'h25: r = 5'd15;
      8'h26: r = 5'd16; 8'h7C: r = 5'd17; 8'h5E: r = 5'd18; 8'h21: r = 5'd19;
      8'h23: r = 5'd20;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // two-character compound index, 31 when none
  function automatic logic [4:0] combo2(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] r;
    r = 5'd31;
    case ({a, b})
      {8'h2B, 8'h3D}: r = 5'd0;  {8'h2D, 8'h3D}: r = 5'd1;
      {8'h2A, 8'h3D}: r = 5'd2;  {8'h2F, 8'h3D}: r = 5'd3;
      {8'h25, 8'h3D}: r = 5'd4;  {8'h3D, 8'h3D}: r = 5'd5;
      {8'h3C, 8'h3D}: r = 5'd6;  {8'h3E, 8'h3D}: r = 5'd7;
      {8'h21, 8'h3D}: r = 5'd8;  {8'h3C, 8'h3C}: r = 5'd9;
      {8'h3E, 8'h3E}: r = 5'd11; {8'h26, 8'h3D}: r = 5'd13;
      {8'h7C, 8'h3D}: r = 5'd14; {8'h5E, 8'h3D}: r = 5'd15;
      {8'h26, 8'h26}: r = 5'd16; {8'h7C, 8'h7C}: r = 5'd17;
      {8'h2D, 8'h3E}: r = 5'd18;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // three-character compounds "<<=" and ">>="
  function automatic logic [4:0] combo3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [4:0] r;
    r = 5'd31;
    if (a == 8'h3C && b == 8'h3C && c == 8'h3D) r = 5'd10;
    else if (a == 8'h3E && b == 8'h3E && c == 8'h3D) r = 5'd12;
    return r;
  endfunction

  // keyword match on packed little-endian text of length len
  function automatic logic [4:0] kw_index(input logic [63:0] t, input logic [3:0] len);
    logic [4:0] r;
    r = 5'd31;
    case ({len, t})
      {4'd2, 64'h6669}:               r = 5'd0;
      {4'd4, 64'h65736C65}:           r = 5'd1;
      {4'd3, 64'h726F66}:             r = 5'd2;
      {4'd5, 64'h656C696877}:         r = 5'd3;
      {4'd6, 64'h6E7275746572}:       r = 5'd4;
      {4'd6, 64'h666F657A6973}:       r = 5'd5;
      {4'd4, 64'h64696F76}:           r = 5'd6;
      {4'd4, 64'h72616863}:           r = 5'd7;
      {4'd3, 64'h746E69}:             r = 5'd8;
      {4'd5, 64'h74616F6C66}:         r = 5'd9;
      {4'd6, 64'h656C62756F64}:       r = 5'd10;
      {4'd8, 64'h64656E6769736E75}:   r = 5'd11;
      {4'd5, 64'h74726F6873}:         r = 5'd12;
      {4'd4, 64'h676E6F6C}:           r = 5'd13;
      {4'd4, 64'h6D756E65}:           r = 5'd14;
      {4'd6, 64'h746375727473}:       r = 5'd15;
      default:                        r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

[design/ctl_stream_if.sv]
interface ctl_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/ctl_core.sv]
// Per-byte lexer step: state registers plus the combinational next-state and
// up to three result words for the byte in flight.
module ctl_core #(
  parameter int LengthBits   = ctl_pkg::DefLengthBits,
  parameter int PositionBits = ctl_pkg::DefPositionBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                c,
  input  logic                      last,
  output logic [2:0]                res_n,
  output logic [3*ctl_pkg::KIND_W-1:0] res_kind,
  output logic [3*PositionBits-1:0] res_start,
  output logic [3*LengthBits-1:0]   res_len,
  output logic [3*ctl_pkg::ERR_W-1:0] res_err
);
  import ctl_pkg::*;

  localparam logic [LengthBits-1:0] LenMax = '1;

  mode_t                   mode, mode_next;
  logic [63:0]             kw, kw_next;
  logic [23:0]             symb, symb_next;
  logic [1:0]              scnt, scnt_next;
  logic [LengthBits-1:0]   sspan, sspan_next;
  logic [KIND_W-1:0]       pk, pk_next;
  logic [PositionBits-1:0] spos, spos_next;
  logic [LengthBits-1:0]   rlen, rlen_next;
  logic [PositionBits-1:0] bpos;
  logic                    err, err_next;

  logic [KIND_W-1:0]       ok [3];
  logic [PositionBits-1:0] os [3];
  logic [LengthBits-1:0]   ol [3];
  logic [ERR_W-1:0]        oe [3];
  logic [1:0]              n;

  logic [LengthBits-1:0] lp1;
  logic [4:0] si, c2, c3, kwi;
  logic ends, redo;
  logic [3:0] kwlen;

  always_comb begin
    lp1   = (rlen != LenMax) ? rlen + 1'b1 : LenMax;
    si    = sym_index(c);
    ends  = is_space(c) || (si != 5'd31);
    c2    = combo2(symb[7:0], c);
    c3    = combo3(symb[7:0], symb[15:8], c);
    kwlen = (rlen <= LengthBits'(8)) ? rlen[3:0] : 4'd15;
    kwi   = kw_index(kw, kwlen);
  end

  // next-state and result assembly
  always_comb begin
    mode_next = mode; kw_next = kw; symb_next = symb; scnt_next = scnt;
    sspan_next = sspan; pk_next = pk; spos_next = spos; rlen_next = rlen;
    err_next = err; n = 2'd0; redo = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ok[i] = K_EOF; os[i] = '0; ol[i] = '0; oe[i] = E_NONE;
    end

    if (!err) begin
      // existing token
      unique case (mode)
        M_IDENT: begin
          if (ends) begin
            ok[0] = (kwi == 5'd31) ? K_IDENT : K_KW0 + KIND_W'(kwi);
            os[0] = spos; ol[0] = rlen; n = 2'd1; mode_next = M_IDLE; redo = 1'b1;
          end else if (is_alpha(c) || c == CH_US) begin
            if (rlen < LengthBits'(8)) kw_next = kw | (64'(c) << {rlen[2:0], 3'b000});
            rlen_next = lp1;
          end else begin
            os[0] = spos; ol[0] = lp1; oe[0] = E_IDENT; n = 2'd1;
            err_next = 1'b1; mode_next = M_IDLE;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(c)) rlen_next = lp1;
          else if (c == CH_DOT && mode == M_INT) begin
            rlen_next = lp1; mode_next = M_FRAC;
          end else if (ends) begin
            ok[0] = (mode == M_INT) ? K_INT : K_FLOAT;
            os[0] = spos; ol[0] = rlen; n = 2'd1; mode_next = M_IDLE; redo = 1'b1;
          end else begin
            os[0] = spos; ol[0] = lp1; oe[0] = E_DIGIT; n = 2'd1;
            err_next = 1'b1; mode_next = M_IDLE;
          end
        end
        M_SYM: begin
          if (is_space(c)) rlen_next = lp1;
          else if (scnt == 2'd1 && symb[7:0] == CH_SLASH && c == CH_SLASH)
            mode_next = M_COMMENT;
          else if (scnt == 2'd1 && c2 != 5'd31) begin
            symb_next[15:8] = c; scnt_next = 2'd2; sspan_next = lp1;
            rlen_next = lp1; pk_next = K_COMBO0 + KIND_W'(c2);
          end else if (scnt == 2'd2 && c3 != 5'd31) begin
            symb_next[23:16] = c; scnt_next = 2'd3; sspan_next = lp1;
            rlen_next = lp1; pk_next = K_COMBO0 + KIND_W'(c3);
          end else begin
            ok[0] = pk; os[0] = spos; ol[0] = sspan; n = 2'd1;
            mode_next = M_IDLE; redo = 1'b1;
          end
        end
        M_CHOPEN: begin rlen_next = lp1; mode_next = M_CHBODY; end
        M_CHBODY: begin
          os[0] = spos; ol[0] = lp1; n = 2'd1; mode_next = M_IDLE;
          if (c == CH_SQ) ok[0] = K_CHAR;
          else begin oe[0] = E_CHARLIT; err_next = 1'b1; end
        end
        M_STRING: begin
          if (c == CH_DQ) begin
            ok[0] = K_STRING; os[0] = spos; ol[0] = lp1; n = 2'd1; mode_next = M_IDLE;
          end else rlen_next = lp1;
        end
        M_COMMENT: if (c == CH_NL) mode_next = M_IDLE;
        default: redo = 1'b1;
      endcase

      // byte starts a new token
      if (redo) begin
        spos_next = bpos; rlen_next = LengthBits'(1);
        if (is_space(c)) mode_next = M_IDLE;
        else if (is_alpha(c)) begin mode_next = M_IDENT; kw_next = 64'(c); end
        else if (is_digit(c)) mode_next = M_INT;
        else if (c == CH_HASH) mode_next = M_COMMENT;
        else if (si != 5'd31) begin
          mode_next = M_SYM; symb_next = 24'(c); scnt_next = 2'd1;
          sspan_next = LengthBits'(1); pk_next = K_SYM0 + KIND_W'(si);
        end else if (c == CH_SQ) mode_next = M_CHOPEN;
        else if (c == CH_DQ) mode_next = M_STRING;
        else begin
          os[n] = bpos; ol[n] = LengthBits'(1); oe[n] = E_UNKNOWN; ok[n] = K_EOF;
          n = n + 2'd1; err_next = 1'b1; mode_next = M_IDLE;
        end
      end
    end

    // end of buffer: flush, then EOF
    if (last) begin
      if (!err_next) begin
        unique case (mode_next)
          M_CHOPEN, M_CHBODY: begin
            os[n] = spos_next; ol[n] = rlen_next; oe[n] = E_CHARLIT; n = n + 2'd1;
          end
          M_STRING: begin
            os[n] = spos_next; ol[n] = rlen_next; oe[n] = E_STRING; n = n + 2'd1;
          end
          M_IDENT: begin
            ok[n] = (kw_index(kw_next, (rlen_next <= LengthBits'(8)) ?
                     rlen_next[3:0] : 4'd15) == 5'd31) ? K_IDENT :
                    K_KW0 + KIND_W'(kw_index(kw_next, rlen_next[3:0]));
            os[n] = spos_next; ol[n] = rlen_next; n = n + 2'd1;
          end
          M_INT, M_FRAC: begin
            ok[n] = (mode_next == M_INT) ? K_INT : K_FLOAT;
            os[n] = spos_next; ol[n] = rlen_next; n = n + 2'd1;
          end
          M_SYM: begin
            ok[n] = pk_next; os[n] = spos_next; ol[n] = sspan_next; n = n + 2'd1;
          end
          default: ;
        endcase
      end
      os[n] = bpos + 1'b1; n = n + 2'd1;
    end
  end

  always_comb begin
    res_n = {1'b0, n} + {2'b00, last & (n == 2'd0)};
    for (int i = 0; i < 3; i++) begin
      res_kind[i*KIND_W +: KIND_W]             = ok[i];
      res_start[i*PositionBits +: PositionBits] = os[i];
      res_len[i*LengthBits +: LengthBits]       = ol[i];
      res_err[i*ERR_W +: ERR_W]                 = oe[i];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      mode <= M_IDLE; kw <= '0; symb <= '0; scnt <= '0; sspan <= '0; pk <= '0;
      spos <= '0; rlen <= '0; bpos <= '0; err <= 1'b0;
    end else if (step) begin
      mode <= mode_next; kw <= kw_next; symb <= symb_next; scnt <= scnt_next;
      sspan <= sspan_next; pk <= pk_next; spos <= spos_next; rlen <= rlen_next;
      bpos <= bpos + 1'b1; err <= err_next;
    end
  end
endmodule

[design/c_token_lexer.sv]
// Channel  | Direction | Word
// src      | in        | char_byte[7:0], last_byte
// tok      | out       | token_kind, token_start, token_length, error_code, last_of_run
//
// One byte is taken per cycle while the FIFO has room; each byte yields 0 to 3 token words, which are
// queued in a 4-entry result FIFO and drained one word per cycle while tok is ready.
// A byte is taken while the FIFO has room for three words, so runs of bytes
// that each give at most one word stream at one byte per cycle while tok is ready.
// Reset (rst, synchronous) clears the lexer state and empties the FIFO.
module c_token_lexer #(
  parameter int LengthBits   = ctl_pkg::DefLengthBits,
  parameter int PositionBits = ctl_pkg::DefPositionBits
) (
  input logic clk,
  input logic rst,
  ctl_stream_if.sink   src,
  ctl_stream_if.source tok
);
  import ctl_pkg::*;

  localparam int OW = KIND_W + PositionBits + LengthBits + ERR_W + 1;
  localparam int Depth = 4;

  logic [2:0] res_n;
  logic [3*KIND_W-1:0] rk;
  logic [3*PositionBits-1:0] rs;
  logic [3*LengthBits-1:0] rl;
  logic [3*ERR_W-1:0] re;
  logic step;

  logic [OW-1:0] fifo [Depth];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  logic pop;

  assign src.ready = (cnt <= 3'd1) || ((cnt == 3'd2) && pop);
  assign step = src.valid && src.ready;
  assign pop = tok.valid && tok.ready;

  ctl_core #(.LengthBits(LengthBits), .PositionBits(PositionBits)) u_core (
    .clk, .rst, .step, .c(src.data[8:1]), .last(src.data[0]),
    .res_n, .res_kind(rk), .res_start(rs), .res_len(rl), .res_err(re)
  );

  // result FIFO
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; cnt <= '0;
    end else begin
      if (step) begin
        for (int i = 0; i < 3; i++) begin
          if (3'(i) < res_n)
            fifo[wr + 2'(i)] <= {rk[i*KIND_W +: KIND_W],
                                 rs[i*PositionBits +: PositionBits],
                                 rl[i*LengthBits +: LengthBits],
                                 re[i*ERR_W +: ERR_W],
                                 (3'(i) == res_n - 3'd1)};
        end
        wr <= wr + res_n[1:0];
      end
      if (pop) rd <= rd + 2'd1;
      cnt <= cnt + (step ? res_n : 3'd0) - {2'b00, pop};
    end
  end

  assign tok.valid = (cnt != 3'd0);
  assign tok.data  = fifo[rd];

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("fifo overflow");
  a_nres: assert property (@(posedge clk) disable iff (rst) step |-> res_n <= 3'd3)
    else $error("too many results");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (step && src.data[0]) |-> res_n != 3'd0)
    else $error("no eof");
endmodule

[tb/sv/ctl_tb_pkg.sv]
package ctl_tb_pkg;
  import ctl_pkg::*;

  // token word layout: kind, start, length, error, last_of_run (lsb)
  typedef logic [57:0] tok_word_t;

  class token_board;
    mode_t       mode;
    logic [63:0] kw_text;
    logic [23:0] sym_text;
    int          sym_cnt;
    int          sym_span;
    logic [5:0]  pend_kind;
    logic [31:0] tok_start;
    int          run_len;
    logic [31:0] byte_pos;
    bit          halted;
    int          words_now;
    tok_word_t   expected_tokens[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      mode = M_IDLE;
      kw_text = '0;
      sym_text = '0;
      sym_cnt = 0;
      sym_span = 0;
      pend_kind = '0;
      tok_start = '0;
      run_len = 0;
      byte_pos = '0;
      halted = 0;
    endfunction

    function bit blank(int c);
      return c == 32 || (c >= 9 && c <= 13);
    endfunction

    function bit letter(int c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function bit digit(int c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function int punct(int c);
      string tab;
      tab = "{}(),;:+-*/<>=.%&|^!#";
      for (int i = 0; i < 21; i++) if (tab[i] == c) return i;
      return -1;
    endfunction

    function int sat(int n);
      return n > 65535 ? 65535 : n;
    endfunction

    function int len_inc();
      return run_len < 65535 ? run_len + 1 : 65535;
    endfunction

    function void emit(logic [5:0] kind, logic [31:0] st, int len, logic [2:0] e);
      if (words_now < 3) begin
        expected_tokens.insert(expected_tokens.size(), {kind, st, 16'(sat(len)), e, 1'b0});
        words_now++;
      end
    endfunction

    function void raise_err(logic [2:0] e, int len);
      emit(K_EOF, tok_start, len, e);
      halted = 1;
      mode = M_IDLE;
    endfunction

    // keyword kind or plain identifier
    function logic [5:0] word_kind();
      string kws[16];
      logic [63:0] p;
      kws = '{"if", "else", "for", "while", "return", "sizeof", "void", "char",
              "int", "float", "double", "unsigned", "short", "long", "enum", "struct"};
      if (run_len > 8) return K_IDENT;
      for (int i = 0; i < 16; i++) begin
        p = '0;
        for (int k = 0; k < kws[i].len(); k++) p[8*k +: 8] = kws[i][k];
        if (kws[i].len() == run_len && p == kw_text) return K_KW0 + 6'(i);
      end
      return K_IDENT;
    endfunction

    function void flush();
      case (mode)
        M_IDENT: emit(word_kind(), tok_start, run_len, E_NONE);
        M_INT:   emit(K_INT, tok_start, run_len, E_NONE);
        M_FRAC:  emit(K_FLOAT, tok_start, run_len, E_NONE);
        M_SYM:   emit(pend_kind, tok_start, sym_span, E_NONE);
        default: ;
      endcase
      mode = M_IDLE;
    endfunction

    function void grow();
      if (run_len < 65535) run_len++;
    endfunction

    function void start_token(int c);
      int s;
      s = punct(c);
      tok_start = byte_pos;
      run_len = 1;
      if (blank(c)) return;
      if (letter(c)) begin
        mode = M_IDENT;
        kw_text = 64'(c);
      end else if (digit(c)) begin
        mode = M_INT;
      end else if (s >= 0) begin
        if (c == CH_HASH) mode = M_COMMENT;
        else begin
          mode = M_SYM;
          sym_text = 24'(c);
          sym_cnt = 1;
          sym_span = 1;
          pend_kind = K_SYM0 + 6'(s);
        end
      end else if (c == CH_SQ) mode = M_CHOPEN;
      else if (c == CH_DQ) mode = M_STRING;
      else raise_err(E_UNKNOWN, 1);
    endfunction

    // returns 1 when the byte must start a new token
    function bit continue_token(int c);
      bit ends;
      int b0, b1;
      string ca, cb;
      bit hit;
      ends = blank(c) || punct(c) >= 0;
      ca = "+-*/%=<>!<<>>&|^&|-";
      cb = "=========<<>>===&|>";
      case (mode)
        M_IDENT: begin
          if (ends) begin
            flush();
            return 1;
          end
          if (letter(c) || c == CH_US) begin
            if (run_len < 8) kw_text[8*run_len +: 8] = 8'(c);
            grow();
          end else raise_err(E_IDENT, len_inc());
          return 0;
        end
        M_INT, M_FRAC: begin
          if (digit(c)) begin
            grow();
            return 0;
          end
          if (c == CH_DOT && mode == M_INT) begin
            grow();
            mode = M_FRAC;
            return 0;
          end
          if (ends) begin
            flush();
            return 1;
          end
          raise_err(E_DIGIT, len_inc());
          return 0;
        end
        M_SYM: begin
          b0 = sym_text[7:0];
          b1 = sym_text[15:8];
          if (blank(c)) begin
            grow();
            return 0;
          end
          if (sym_cnt == 1 && b0 == CH_SLASH && c == CH_SLASH) begin
            mode = M_COMMENT;
            return 0;
          end
          for (int i = 0; i < 19 && sym_cnt < 3; i++) begin
            // entries 10 and 12 are the three-byte shifts-assign
            if (sym_cnt == 1) hit = (i != 10 && i != 12) && ca[i] == b0 && cb[i] == c;
            else hit = (i == 10 || i == 12) && ca[i] == b0 && cb[i] == b1 && c == 8'h3D;
            if (hit) begin
              sym_text[8*sym_cnt +: 8] = 8'(c);
              sym_cnt++;
              sym_span = len_inc();
              grow();
              pend_kind = K_COMBO0 + 6'(i);
              return 0;
            end
          end
          flush();
          return 1;
        end
        M_CHOPEN: begin
          grow();
          mode = M_CHBODY;
          return 0;
        end
        M_CHBODY: begin
          if (c == CH_SQ) begin
            emit(K_CHAR, tok_start, len_inc(), E_NONE);
            mode = M_IDLE;
          end else raise_err(E_CHARLIT, len_inc());
          return 0;
        end
        M_STRING: begin
          if (c == CH_DQ) begin
            emit(K_STRING, tok_start, len_inc(), E_NONE);
            mode = M_IDLE;
          end else grow();
          return 0;
        end
        M_COMMENT: begin
          if (c == CH_NL) mode = M_IDLE;
          return 0;
        end
        default: return 1;
      endcase
    endfunction

    // accepted source byte: append the token words it causes
    function void note_byte(logic [7:0] c, bit last);
      int mark;
      mark = expected_tokens.size();
      words_now = 0;
      if (!halted && continue_token(c)) start_token(c);
      if (last) begin
        if (!halted) begin
          if (mode == M_CHOPEN || mode == M_CHBODY) raise_err(E_CHARLIT, run_len);
          else if (mode == M_STRING) raise_err(E_STRING, run_len);
          else flush();
        end
        emit(K_EOF, byte_pos + 1, 0, E_NONE);
        clear();
      end else byte_pos++;
      if (expected_tokens.size() > mark) expected_tokens[expected_tokens.size() - 1][0] = 1'b1;
    endfunction

    function void check_token(tok_word_t got);
      tok_word_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token word %h", got);
        return;
      end
      want = expected_tokens.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"token mismatch: kind %0d/%0d start %0d/%0d len %0d/%0d",
                    " err %0d/%0d last %0d/%0d"},
                   want[57:52], got[57:52], want[51:20], got[51:20], want[19:4], got[19:4],
                   want[3:1], got[3:1], want[0], got[0]);
      end
    endfunction
  endclass
endpackage

[tb/sv/tb_top.sv]
module tb_top;
  import ctl_pkg::*;
  import ctl_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  ctl_stream_if #(.W(9))  src_if ();
  ctl_stream_if #(.W(58)) tok_if ();

  token_board board = new();
  bit   src_idle_on = 1;
  bit   tok_stall_on = 1;
  int   bytes_sent = 0;
  int   stall_left = 0;
  byte unsigned text[$];

  c_token_lexer dut (
    .clk(clk),
    .rst(rst),
    .src(src_if.sink),
    .tok(tok_if.source)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    src_if.valid = 0;
    src_if.data  = '0;
    tok_if.ready = 0;
  end

  // token sink: check each taken word, stall in random bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_if.valid && tok_if.ready) board.check_token(tok_if.data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        tok_if.ready <= 0;
      end else if (tok_stall_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 16);
        tok_if.ready <= 0;
      end else tok_if.ready <= 1;
    end
  end

  task automatic send_byte(byte unsigned c, bit last);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      src_if.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    src_if.valid <= 1;
    src_if.data  <= {c, last};
    do @(posedge clk); while (!src_if.ready);
    board.note_byte(c, last);
    bytes_sent++;
  endtask

  // send the text buffer, last flag on its final byte
  task automatic send_buffer();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic add(string s);
    for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
  endtask

  // one random fragment of source text
  task automatic add_fragment();
    string frags[28];
    frags = '{"if", "else", "while", "return", "sizeof", "unsigned", "struct", "float",
              "foo_bar", "x", "Iff", "12", "3.75", "7.", "'q'", "\"ab c\"", "<<=", ">>=",
              "->", "&&", "||", "!=", "< <", "/ /c\n", "# def\n", "{", ";", "ab9"};
    case ($urandom_range(0, 9))
      0: text.insert(text.size(), 8'($urandom_range(0, 255)));
      1: add(" ");
      default: add(frags[$urandom_range(0, 27)]);
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: keyword, unknown bytes, float, char and string errors, symbols, ident error
    add("int _");
    send_buffer();
    add("1.5+");
    send_buffer();
    text.insert(text.size(), 8'h00);
    text.insert(text.size(), 8'hFF);
    send_buffer();
    add("'ab");
    send_buffer();
    add("\"x");
    send_buffer();
    add(">> =x");
    send_buffer();
    add("a1");
    send_buffer();

    // random buffers of well-formed fragments with noise
    while (bytes_sent < 210) begin
      if (bytes_sent > 170) begin
        src_idle_on = 0;
        tok_stall_on = 0;
      end
      repeat ($urandom_range(1, 8)) add_fragment();
      send_buffer();
    end
    src_if.valid <= 0;

    while (board.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.expected_tokens.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
